>>> hdl/wrapped_midpoint_circle_raster_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wrapped midpoint circle rasteriser
// Shared forms for the concurrent checks on the top level's ports.
// ----------------------------------------------------------------------------
`ifndef WRAPPED_MIDPOINT_CIRCLE_RASTER_TOP_ASSERT_SVH
`define WRAPPED_MIDPOINT_CIRCLE_RASTER_TOP_ASSERT_SVH

// The consequent is checked in the same cycle as the antecedent.
`define WMCR_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define WMCR_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> hdl/wmcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrapped midpoint circle rasteriser package
// Widths, reset values, register indexes and the control structures.
// ----------------------------------------------------------------------------
package wmcr_pkg;

    localparam int COORD_BITS_DEFAULT = 11;
    localparam int MAX_RADIUS         = 31;

    localparam int RAD_BITS     = 5;
    localparam int STEPX_BITS   = RAD_BITS + 2;
    localparam int STEPY_BITS   = RAD_BITS + 1;
    localparam int TERM_BITS    = 8;
    localparam int ERR_BITS     = 9;
    localparam int ERR_EXT_BITS = ERR_BITS + 2;

    localparam int SCREEN_WIDTH_RESET  = 640;
    localparam int SCREEN_HEIGHT_RESET = 480;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    // Register index, taken from address bit 2.
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    typedef struct packed {
        logic load;
        logic emit;
        logic phase;
    } dp_cmd_t;

    typedef struct packed {
        logic zero_radius;
        logic loop_done;
    } dp_status_t;

endpackage

>>> hdl/wmcr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrapped midpoint circle rasteriser controller
// Sequences one circle command and owns the result valid flag.
// ----------------------------------------------------------------------------
module wmcr_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  out_stall,
    input  wmcr_pkg::dp_status_t  status,
    output wmcr_pkg::dp_cmd_t     cmd,
    output logic                  in_stall,
    output logic                  out_valid
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   phase_reg;
    logic   phase_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   can_emit;

    assign can_emit = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.load       = 1'b0;
        cmd.emit       = 1'b0;
        cmd.phase      = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid && !status.zero_radius)
                begin
                    state_next = ST_RUN;
                    phase_next = 1'b0;
                end
            end
            ST_RUN:
            begin
                if (can_emit)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    phase_next     = !phase_reg;
                    if (phase_reg && status.loop_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> hdl/wmcr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrapped midpoint circle rasteriser datapath
// Midpoint error terms, octant point generation, wrap and result register.
// ----------------------------------------------------------------------------
module wmcr_datapath
#(
    parameter int COORD_BITS = wmcr_pkg::COORD_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  wmcr_pkg::dp_cmd_t             cmd,
    output wmcr_pkg::dp_status_t          status,
    input  logic [COORD_BITS-1:0]         center_x,
    input  logic [COORD_BITS-1:0]         center_y,
    input  logic [wmcr_pkg::RAD_BITS-1:0] radius,
    input  logic [COORD_BITS-1:0]         screen_width,
    input  logic [COORD_BITS-1:0]         screen_height,
    output logic [COORD_BITS-1:0]         pa_x,
    output logic [COORD_BITS-1:0]         pa_y,
    output logic [COORD_BITS-1:0]         pb_x,
    output logic [COORD_BITS-1:0]         pb_y,
    output logic [COORD_BITS-1:0]         pc_x,
    output logic [COORD_BITS-1:0]         pc_y,
    output logic [COORD_BITS-1:0]         pd_x,
    output logic [COORD_BITS-1:0]         pd_y,
    output logic                          last
);

    localparam int RB = wmcr_pkg::RAD_BITS;
    localparam int XB = wmcr_pkg::STEPX_BITS;
    localparam int YB = wmcr_pkg::STEPY_BITS;
    localparam int TB = wmcr_pkg::TERM_BITS;
    localparam int EB = wmcr_pkg::ERR_BITS;
    localparam int EW = wmcr_pkg::ERR_EXT_BITS;
    localparam int VW = COORD_BITS + 2;

    // A point below zero gets the size added once, one at or above it gets
    // the size taken off once; the result is then cut to the port width.
    function automatic logic [COORD_BITS-1:0] wrap_coord(
        input logic signed [VW-1:0] v,
        input logic [COORD_BITS-1:0] size
    );
        logic signed [VW-1:0] s;
        logic signed [VW-1:0] w;
        s = $signed({2'b00, size});
        if (v < 0)
            w = v + s;
        else if (v >= s)
            w = v - s;
        else
            w = v;
        return w[COORD_BITS-1:0];
    endfunction

    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cy_reg;
    logic [RB-1:0]         rad_reg;
    logic signed [XB-1:0]  x_reg;
    logic [YB-1:0]         y_reg;
    logic [TB-1:0]         tx_reg;
    logic [TB-1:0]         ty_reg;
    logic signed [EB-1:0]  err_reg;

    logic [RB-1:0]         r_sat;
    logic                  err_le0;
    logic signed [EW-1:0]  err_a;
    logic signed [EW-1:0]  err_b;
    logic [TB-1:0]         tx_inc;
    logic [TB-1:0]         ty_inc;
    logic signed [XB-1:0]  x_next;
    logic [YB-1:0]         y_next;
    logic [TB-1:0]         tx_next;
    logic [TB-1:0]         ty_next;
    logic signed [EB-1:0]  err_next;

    logic [XB-1:0]         u_off;
    logic [XB-1:0]         v_off;
    logic signed [VW-1:0]  cx_ext;
    logic signed [VW-1:0]  cy_ext;
    logic signed [VW-1:0]  u_ext;
    logic signed [VW-1:0]  v_ext;
    logic [COORD_BITS-1:0] wx_pos;
    logic [COORD_BITS-1:0] wx_neg;
    logic [COORD_BITS-1:0] wy_pos;
    logic [COORD_BITS-1:0] wy_neg;

    // Radius clamp; the comparison runs at 32 bits so any limit fits.
    assign r_sat = (32'(radius) > wmcr_pkg::MAX_RADIUS) ?
                   RB'(wmcr_pkg::MAX_RADIUS) : radius;

    // One midpoint step: first the row move, then the column move.
    always_comb
    begin
        err_le0 = (err_reg <= 0);
        ty_inc  = ty_reg + TB'(2);
        tx_inc  = tx_reg + TB'(2);
        if (err_le0)
        begin
            err_a   = $signed({{2{err_reg[EB-1]}}, err_reg})
                    + $signed({{(EW-TB){1'b0}}, ty_reg});
            y_next  = y_reg + YB'(1);
            ty_next = ty_inc;
        end
        else
        begin
            err_a   = $signed({{2{err_reg[EB-1]}}, err_reg});
            y_next  = y_reg;
            ty_next = ty_reg;
        end
        err_b = err_a + $signed({{(EW-TB){1'b0}}, tx_inc})
              - $signed({{(EW-RB-1){1'b0}}, rad_reg, 1'b0});
        if (err_a > 0)
        begin
            x_next   = x_reg - XB'(1);
            tx_next  = tx_inc;
            err_next = err_b[EB-1:0];
        end
        else
        begin
            x_next   = x_reg;
            tx_next  = tx_reg;
            err_next = err_a[EB-1:0];
        end
    end

    assign status.zero_radius = (r_sat == '0);
    assign status.loop_done   = (x_next < $signed({1'b0, y_next}));

    // The first result of a step uses (x, y), the second swaps them.
    assign u_off  = cmd.phase ? {1'b0, y_reg} : x_reg;
    assign v_off  = cmd.phase ? x_reg : {1'b0, y_reg};
    assign cx_ext = $signed({2'b00, cx_reg});
    assign cy_ext = $signed({2'b00, cy_reg});
    assign u_ext  = $signed({{(VW-XB){1'b0}}, u_off});
    assign v_ext  = $signed({{(VW-XB){1'b0}}, v_off});
    assign wx_pos = wrap_coord(cx_ext + u_ext, screen_width);
    assign wx_neg = wrap_coord(cx_ext - u_ext, screen_width);
    assign wy_pos = wrap_coord(cy_ext + v_ext, screen_height);
    assign wy_neg = wrap_coord(cy_ext - v_ext, screen_height);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg  <= center_x;
            cy_reg  <= center_y;
            rad_reg <= r_sat;
            x_reg   <= $signed({2'b00, r_sat}) - XB'(1);
            y_reg   <= '0;
            tx_reg  <= TB'(1);
            ty_reg  <= TB'(1);
            err_reg <= EB'(1) - $signed({{(EB-RB-1){1'b0}}, r_sat, 1'b0});
        end
        else if (cmd.emit && cmd.phase)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
            err_reg <= err_next;
        end

        if (cmd.emit)
        begin
            pa_x <= wx_pos;
            pa_y <= wy_neg;
            pb_x <= wx_pos;
            pb_y <= wy_pos;
            pc_x <= wx_neg;
            pc_y <= wy_neg;
            pd_x <= wx_neg;
            pd_y <= wy_pos;
            last <= cmd.phase && status.loop_done;
        end
    end

endmodule

>>> hdl/wrapped_midpoint_circle_raster_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrapped midpoint circle rasteriser
// Turns circle commands into outline points on a wrapping screen.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ------------------------------------
//  in        in_valid / in_stall       center_x, center_y, radius
//  out       out_valid / out_stall     pa_x .. pd_y, last
//  cfg       psel, penable, pwrite     paddr, pwdata, prdata (pready high)
//
// A circle command is accepted, then the block emits two result items per
// midpoint step, so a circle yields 2*N items where N is about 0.71*radius
// steps. The pace is set by the single shared point generator, which
// produces one half of a step a cycle while the output is not stalled. A
// zero radius command yields no item and the block stays ready. Reset returns
// the controller to idle with no item pending; the screen size registers
// return to 640 by 480. A stalled output holds its item and the stepping
// waits; the next command is taken while the last item still waits.
//
module wrapped_midpoint_circle_raster_top
#(
    parameter int COORD_BITS = wmcr_pkg::COORD_BITS_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [COORD_BITS-1:0]              center_x,
    input  logic [COORD_BITS-1:0]              center_y,
    input  logic [wmcr_pkg::RAD_BITS-1:0]      radius,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [COORD_BITS-1:0]              pa_x,
    output logic [COORD_BITS-1:0]              pa_y,
    output logic [COORD_BITS-1:0]              pb_x,
    output logic [COORD_BITS-1:0]              pb_y,
    output logic [COORD_BITS-1:0]              pc_x,
    output logic [COORD_BITS-1:0]              pc_y,
    output logic [COORD_BITS-1:0]              pd_x,
    output logic [COORD_BITS-1:0]              pd_y,
    output logic                               last,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wmcr_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [wmcr_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [wmcr_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);

    localparam int DB = wmcr_pkg::APB_DATA_BITS;

    // Screen size registers. Address bit 2 selects the register; the low
    // address bits select a byte within the word and do not matter here.
    logic [COORD_BITS-1:0] screen_width_reg;
    logic [COORD_BITS-1:0] screen_height_reg;
    logic                  cfg_write;

    wmcr_pkg::dp_cmd_t     cmd;
    wmcr_pkg::dp_status_t  status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= COORD_BITS'(wmcr_pkg::SCREEN_WIDTH_RESET);
            screen_height_reg <= COORD_BITS'(wmcr_pkg::SCREEN_HEIGHT_RESET);
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                wmcr_pkg::REG_SCREEN_WIDTH:
                    screen_width_reg <= pwdata[COORD_BITS-1:0];
                wmcr_pkg::REG_SCREEN_HEIGHT:
                    screen_height_reg <= pwdata[COORD_BITS-1:0];
                default:
                    screen_width_reg <= screen_width_reg;
            endcase
        end
    end

    // Reads return the addressed register, zero extended to the bus width.
    always_comb
    begin
        unique case (paddr[2])
            wmcr_pkg::REG_SCREEN_WIDTH:
                prdata = {{(DB-COORD_BITS){1'b0}}, screen_width_reg};
            wmcr_pkg::REG_SCREEN_HEIGHT:
                prdata = {{(DB-COORD_BITS){1'b0}}, screen_height_reg};
            default:
                prdata = '0;
        endcase
    end

    // The controller decides when a command is loaded and when each half
    // step is written to the result register; the datapath does the rest.
    wmcr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    wmcr_datapath
    #(
        .COORD_BITS (COORD_BITS)
    )
    u_datapath
    (
        .clk           (clk),
        .cmd           (cmd),
        .status        (status),
        .center_x      (center_x),
        .center_y      (center_y),
        .radius        (radius),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .pa_x          (pa_x),
        .pa_y          (pa_y),
        .pb_x          (pb_x),
        .pb_y          (pb_y),
        .pc_x          (pc_x),
        .pc_y          (pc_y),
        .pd_x          (pd_x),
        .pd_y          (pd_y),
        .last          (last)
    );

endmodule

>>> hdl/wmcr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrapped midpoint circle rasteriser port checker
// Concurrent checks on the top level's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`include "wrapped_midpoint_circle_raster_top_assert.svh"

module wmcr_checker
#(
    parameter int COORD_BITS = wmcr_pkg::COORD_BITS_DEFAULT
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [wmcr_pkg::RAD_BITS-1:0] radius,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [COORD_BITS-1:0]         pa_x,
    input logic                          last
);

    // A stalled item stays on the port unchanged.
    `WMCR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pa_x) && $stable(last), "stalled result item changed")

    // A command with a non-zero radius makes the block busy.
    `WMCR_ASSERT_NEXT(a_busy_after_cmd, in_valid && !in_stall && (radius != '0), in_stall, "block not busy after a circle command")

    // While idle, no new result can appear in the following cycle.
    `WMCR_ASSERT_NEXT(a_idle_no_result, !in_stall && out_valid && !out_stall, !out_valid, "result item appeared while idle")

    // The block goes idle only with the final item of the circle on the port.
    `WMCR_ASSERT_SAME(a_idle_after_last, $fell(in_stall), out_valid && last, "block went idle without a final item")

endmodule

bind wrapped_midpoint_circle_raster_top wmcr_checker
#(
    .COORD_BITS (COORD_BITS)
)
u_wmcr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .radius    (radius),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pa_x      (pa_x),
    .last      (last)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the wrapped midpoint circle rasteriser
// Sends circle commands with random gaps and output stalls, predicts the
// outline points of every command on the wrapping screen, and checks each
// outline item field by field as the block hands it over. It also steps
// through several screen sizes, the extremes among them.
// ----------------------------------------------------------------------------
module tb;

    localparam int COORD_BITS     = wmcr_pkg::COORD_BITS_DEFAULT;
    localparam int AB             = wmcr_pkg::APB_ADDR_BITS;
    localparam int DB             = wmcr_pkg::APB_DATA_BITS;
    // Cycles with no handshake of any kind before the run is abandoned.
    // The slowest correct stretch is a long output stall or a settling pause.
    localparam int WATCHDOG_LIMIT = 4000;
    // Time allowed for a zero radius command to clear before a register write.
    localparam int SETTLE_CYCLES  = 8;
    // Quiet period at the end, longer than the slowest circle.
    localparam int TAIL_CYCLES    = 64;

    localparam logic [AB-1:0] ADDR_SCREEN_WIDTH  = {wmcr_pkg::REG_SCREEN_WIDTH, 2'b00};
    localparam logic [AB-1:0] ADDR_SCREEN_HEIGHT = {wmcr_pkg::REG_SCREEN_HEIGHT, 2'b00};

    // Directed commands, taken on the reset screen of 640 by 480: zero radius
    // (twice in a row), the smallest and largest radii, centres on the screen
    // corners so that points wrap both ways, centres off the screen so that
    // the wrapped value stays out of range or goes negative, and alternating
    // bit patterns in the centre.
    localparam int NUM_DIRECTED = 14;
    localparam int DIRECTED_CMDS [NUM_DIRECTED][3] = '{
        '{320, 240, 0},   '{320, 240, 1},   '{320, 240, 2},   '{320, 240, 31},
        '{0, 0, 31},      '{639, 479, 31},  '{2047, 2047, 31}, '{2047, 0, 7},
        '{0, 2047, 7},    '{1024, 1024, 16}, '{5, 5, 0},       '{6, 6, 0},
        '{100, 100, 3},   '{1365, 682, 21}
    };

    typedef logic [COORD_BITS-1:0]          coord_t;
    typedef logic [wmcr_pkg::RAD_BITS-1:0]  radius_t;

    // One outline item: four wrapped points and the end-of-circle flag.
    typedef struct packed {
        coord_t pa_x;
        coord_t pa_y;
        coord_t pb_x;
        coord_t pb_y;
        coord_t pc_x;
        coord_t pc_y;
        coord_t pd_x;
        coord_t pd_y;
        logic   last;
    } outline_item_t;

    // ------------------------------------------------------------------------
    // Scoreboard: traces each accepted circle into its outline items and
    // matches the block's items against them in order.
    // ------------------------------------------------------------------------
    class outline_scoreboard;
        coord_t        screen_w;
        coord_t        screen_h;
        outline_item_t pending[$];
        int            fails;

        function new();
            screen_w = coord_t'(wmcr_pkg::SCREEN_WIDTH_RESET);
            screen_h = coord_t'(wmcr_pkg::SCREEN_HEIGHT_RESET);
            fails    = 0;
        endfunction

        // A coordinate wraps once around the screen size and is then cut to
        // the coordinate width, so a far off-screen value stays off screen.
        function coord_t wrap_to_screen(int v, int size);
            if (v < 0)
                v += size;
            else if (v >= size)
                v -= size;
            return v[COORD_BITS-1:0];
        endfunction

        // The four points mirrored about the centre for offsets dx and dy.
        function outline_item_t mirror_points(coord_t cx, coord_t cy, int dx, int dy);
            outline_item_t item;
            item.pa_x = wrap_to_screen(int'(cx) + dx, int'(screen_w));
            item.pa_y = wrap_to_screen(int'(cy) - dy, int'(screen_h));
            item.pb_x = wrap_to_screen(int'(cx) + dx, int'(screen_w));
            item.pb_y = wrap_to_screen(int'(cy) + dy, int'(screen_h));
            item.pc_x = wrap_to_screen(int'(cx) - dx, int'(screen_w));
            item.pc_y = wrap_to_screen(int'(cy) - dy, int'(screen_h));
            item.pd_x = wrap_to_screen(int'(cx) - dx, int'(screen_w));
            item.pd_y = wrap_to_screen(int'(cy) + dy, int'(screen_h));
            item.last = 1'b0;
            return item;
        endfunction

        // Walks one octant by the midpoint method; every step yields the
        // x-major half and then the y-major half of the eight points.
        function void note_circle(coord_t cx, coord_t cy, radius_t rad);
            int step_x;
            int step_y;
            int inc_x;
            int inc_y;
            int err;
            int diam;
            int first;
            diam   = 2 * int'(rad);
            step_x = int'(rad) - 1;
            step_y = 0;
            inc_x  = 1;
            inc_y  = 1;
            err    = 1 - diam;
            first  = pending.size();
            while (step_x >= step_y)
            begin
                pending.push_back(mirror_points(cx, cy, step_x, step_y));
                pending.push_back(mirror_points(cx, cy, step_y, step_x));
                if (err <= 0)
                begin
                    step_y = step_y + 1;
                    err    = err + inc_y;
                    inc_y  = inc_y + 2;
                end
                if (err > 0)
                begin
                    step_x = step_x - 1;
                    inc_x  = inc_x + 2;
                    err    = err + inc_x - diam;
                end
            end
            if (pending.size() > first)
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string field, coord_t want, coord_t got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                fails++;
            end
        endfunction

        function void check_item(outline_item_t got);
            outline_item_t want;
            if (pending.size() == 0)
            begin
                $error("outline item arrived with none expected");
                fails++;
                return;
            end
            want = pending.pop_front();
            compare_field("pa_x", want.pa_x, got.pa_x);
            compare_field("pa_y", want.pa_y, got.pa_y);
            compare_field("pb_x", want.pb_x, got.pb_x);
            compare_field("pb_y", want.pb_y, got.pb_y);
            compare_field("pc_x", want.pc_x, got.pc_x);
            compare_field("pc_y", want.pc_y, got.pc_y);
            compare_field("pd_x", want.pd_x, got.pd_x);
            compare_field("pd_y", want.pd_y, got.pd_y);
            compare_field("last", coord_t'(want.last), coord_t'(got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    coord_t        center_x;
    coord_t        center_y;
    radius_t       radius;
    logic          out_valid;
    logic          out_stall;
    coord_t        pa_x;
    coord_t        pa_y;
    coord_t        pb_x;
    coord_t        pb_y;
    coord_t        pc_x;
    coord_t        pc_y;
    coord_t        pd_x;
    coord_t        pd_y;
    logic          last;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [AB-1:0] paddr;
    logic [DB-1:0] pwdata;
    logic [DB-1:0] prdata;
    logic          pready;

    outline_scoreboard sb;
    int                idle_cycles = 0;

    wrapped_midpoint_circle_raster_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius    (radius),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pa_x      (pa_x),
        .pa_y      (pa_y),
        .pb_x      (pb_x),
        .pb_y      (pb_y),
        .pc_x      (pc_x),
        .pc_y      (pc_y),
        .pd_x      (pd_x),
        .pd_y      (pd_y),
        .last      (last),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_gap();
        int pick;
        pick = int'($urandom_range(0, 99));
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return int'($urandom_range(1, 3));
        else
            return int'($urandom_range(8, 40));
    endfunction

    // ------------------------------------------------------------------------
    // Output side: stall runs and free runs of random length follow in random order, so
    // that stalls land on every half of a midpoint step and on the last item.
    // ------------------------------------------------------------------------
    initial
    begin
        int   run;
        logic hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                hold = 1'b1;
                run  = idle_gap();
            end
            else
            begin
                hold = 1'b0;
                run  = int'($urandom_range(1, 30));
            end
            if (run > 0)
            begin
                @(negedge clk);
                out_stall = hold;
                repeat (run - 1) @(negedge clk);
            end
        end
    end

    // Every outline item taken from the block is checked at the edge that
    // accepts it. Values read here are those from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_item(outline_item_t'({pa_x, pa_y, pb_x, pb_y, pc_x, pc_y,
                                           pd_x, pd_y, last}));
    end

    // Watchdog: any handshake on the command, outline or register channel
    // counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("No handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks. Inputs change at the falling edge only.
    // ------------------------------------------------------------------------

    // Presents one circle command and holds it until the block takes it.
    task automatic send_circle(input coord_t cx, input coord_t cy, input radius_t rad);
        @(negedge clk);
        in_valid = 1'b1;
        center_x = cx;
        center_y = cy;
        radius   = rad;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_circle(cx, cy, rad);
    endtask

    // Leaves the command channel empty for the given number of cycles.
    task automatic rest_sender(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Stops sending and waits until every predicted item has come out.
    task automatic drain_outline();
        rest_sender(1);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // One register access: a setup phase, then an access phase that ends at
    // the edge where pready is seen high.
    task automatic apb_access(input logic wr, input logic [AB-1:0] addr,
                              input logic [DB-1:0] wdata,
                              output logic [DB-1:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Changes the screen size once the block is idle, then reads both
    // registers back.
    task automatic set_screen(input coord_t w, input coord_t h);
        logic [DB-1:0] rd;
        logic [AB-1:0] addr [2];
        coord_t        val [2];
        drain_outline();
        // A trailing zero radius command yields nothing, so give it time.
        repeat (SETTLE_CYCLES) @(posedge clk);
        addr = '{ADDR_SCREEN_WIDTH, ADDR_SCREEN_HEIGHT};
        val  = '{w, h};
        for (int i = 0; i < 2; i++)
            apb_access(1'b1, addr[i], DB'(val[i]), rd);
        sb.screen_w = w;
        sb.screen_h = h;
        for (int i = 0; i < 2; i++)
        begin
            apb_access(1'b0, addr[i], '0, rd);
            if (rd !== DB'(val[i]))
            begin
                $error("register at %0d: expected %0d, got %0d", addr[i], val[i], rd);
                sb.fails++;
            end
        end
    endtask

    // Random commands on the current screen. Most centres lie on the screen,
    // as the block expects; the rest are anywhere in the coordinate range.
    // Some phases run without any gap at all.
    task automatic run_phase(input int count);
        coord_t  cx;
        coord_t  cy;
        radius_t rad;
        bit      steady;
        steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 8 && sb.screen_w != 0 && sb.screen_h != 0)
            begin
                cx = coord_t'($urandom_range(0, int'(sb.screen_w) - 1));
                cy = coord_t'($urandom_range(0, int'(sb.screen_h) - 1));
            end
            else
            begin
                cx = coord_t'($urandom_range(0, (1 << COORD_BITS) - 1));
                cy = coord_t'($urandom_range(0, (1 << COORD_BITS) - 1));
            end
            rad = radius_t'($urandom_range(0, (1 << wmcr_pkg::RAD_BITS) - 1));
            send_circle(cx, cy, rad);
            // Now and then hold off until the block has emptied completely.
            if ($urandom_range(0, 39) == 0)
                drain_outline();
            else
                rest_sender(steady ? 0 : idle_gap());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        center_x    = '0;
        center_y    = '0;
        radius      = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed commands on the screen size left by reset.
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            send_circle(coord_t'(DIRECTED_CMDS[i][0]), coord_t'(DIRECTED_CMDS[i][1]),
                        radius_t'(DIRECTED_CMDS[i][2]));
            rest_sender(idle_gap());
        end

        // Random commands over a range of screens: the smallest, the largest,
        // a zero size that leaves coordinates unwrapped, lopsided ones, random
        // ones, and finally the reset size again.
        set_screen(coord_t'(1), coord_t'(1));
        run_phase(55);
        set_screen(coord_t'(2047), coord_t'(2047));
        run_phase(55);
        set_screen(coord_t'(0), coord_t'(0));
        run_phase(40);
        set_screen(coord_t'($urandom_range(1, 2047)), coord_t'($urandom_range(1, 2047)));
        run_phase(60);
        set_screen(coord_t'(2047), coord_t'(1));
        run_phase(50);
        set_screen(coord_t'($urandom_range(8, 64)), coord_t'($urandom_range(8, 64)));
        run_phase(60);
        set_screen(coord_t'(wmcr_pkg::SCREEN_WIDTH_RESET),
                   coord_t'(wmcr_pkg::SCREEN_HEIGHT_RESET));
        run_phase(65);

        drain_outline();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/wmcr_pkg.sv
hdl/wmcr_ctrl.sv
hdl/wmcr_datapath.sv
hdl/wrapped_midpoint_circle_raster_top.sv
hdl/wmcr_checker.sv
tb/sv/tb.sv
